@@ hw/rtl/escape_sequence_to_utf8_decoder_assert.svh @@
// Assertion macros for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_TO_UTF8_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_TO_UTF8_DECODER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ESUD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ESUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/esud_pkg.sv @@
// Shared types, constants and helper functions for the escape sequence decoder.
`timescale 1ns / 1ps

package esud_pkg;

    // Escape parser phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_BSLASH = 4'd1,
        PH_CR     = 4'd2,
        PH_ZERO   = 4'd3,
        PH_X      = 4'd4,
        PH_U      = 4'd5,
        PH_U4     = 4'd6,
        PH_UBRACE = 4'd7,
        PH_LA_BS  = 4'd8,
        PH_LA_U   = 4'd9,
        PH_LA_D   = 4'd10
    } phase_t;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Code point limits
    localparam logic [24:0] CP_MAX      = 25'h10FFFF;
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] CP_SUPP     = 21'h10000;

    // Result items per input item
    localparam logic [4:0] MAX_OUT = 5'd20;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic eval;
        logic flush;
        logic lit;
        logic rd_start;
        logic rep;
        logic cpa;
        logic cpb;
        logic done;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic        plan_lit;
        logic        plan_rep;
        logic        plan_cpa;
        logic        plan_cpb;
        logic        plan_reproc;
        logic        plan_idle;
        logic        job_lit_one;
        logic        job_rep;
        logic        job_rep_last;
        logic        job_cpa;
        logic        job_cpa_last;
        logic        job_cpb;
        logic        job_cpb_last;
        logic        reproc;
        logic        phase_idle;
        logic        last;
        logic        can_put;
        logic        pend_valid;
        logic [15:0] line_cnt;
    } status_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
            || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
        else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
        return v[3:0];
    endfunction

    // Number of UTF-8 bytes minus one
    function automatic logic [1:0] utf8_len(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h80) n = 2'd0;
        else if (cp < 21'h800) n = 2'd1;
        else if (cp < 21'h10000) n = 2'd2;
        else n = 2'd3;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (utf8_len(cp))
            2'd0: r = cp[7:0];
            2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2:
            begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/esud_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module esud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/esud_datapath.sv @@
// Datapath: escape parser registers, held digit store, UTF-8 emitter and output stage.
`timescale 1ns / 1ps

module esud_datapath #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  esud_pkg::cmd_t   cmd,
    output esud_pkg::status_t status,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic [15:0]      out_lines
);

    import esud_pkg::*;

    localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int ADDR_W = $clog2(HOLD_DEPTH);

    // Parser state
    phase_t             phase_reg, ph_n;
    logic [20:0]        acc_reg, acc_n;
    logic [15:0]        hi_reg, hi_n;
    logic [15:0]        la_reg, la_n;
    logic [CNT_W-1:0]   held_reg, held_n;
    logic [15:0]        line_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;

    // Jobs planned by the last evaluation
    logic [1:0]         lit_n_reg;
    logic [7:0]         lit0_reg, lit1_reg;
    logic [CNT_W-1:0]   rep_cnt_reg;
    logic [ADDR_W-1:0]  rep_idx_reg;
    logic               cpa_v_reg, cpb_v_reg;
    logic [20:0]        cpa_reg;
    logic [15:0]        cpb_reg;
    logic [1:0]         cp_idx_reg;
    logic               reproc_reg;

    // Output stage
    logic               pend_valid_reg;
    logic [7:0]         pend_byte_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic [15:0]        out_lines_reg;
    logic [4:0]         step_cnt_reg;

    // Evaluation results
    logic [1:0]         lit_n_p;
    logic [7:0]         lit0_p, lit1_p;
    logic               rep_p, cpa_v_p, cpb_v_p, reproc_p;
    logic [20:0]        cpa_p;
    logic [15:0]        cpb_p;
    logic               hold_we;
    logic [CNT_W-1:0]   hold_addr;
    logic               do_fail, do_drop;

    logic               hx;
    logic [3:0]         hv;
    logic [24:0]        brace_nc;
    logic [15:0]        u4_new, la_new;

    logic [7:0]         ram_rd_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [CNT_W-1:0]   rep_idx_inc;
    logic               rep_last;

    logic               out_free, can_put, put_en, line_inc, out_load;
    logic [7:0]         put_byte;

    assign hx       = is_hex(byte_reg);
    assign hv       = hex_val(byte_reg);
    assign brace_nc = {acc_reg, hv};
    assign u4_new   = {acc_reg[11:0], hv};
    assign la_new   = {la_reg[11:0], hv};

    // Evaluate one parser step on the held item
    always_comb
    begin
        ph_n      = phase_reg;
        acc_n     = acc_reg;
        hi_n      = hi_reg;
        la_n      = la_reg;
        held_n    = held_reg;
        hold_we   = 1'b0;
        hold_addr = held_reg;
        lit_n_p   = 2'd0;
        lit0_p    = byte_reg;
        lit1_p    = CH_LBRACE;
        rep_p     = 1'b0;
        cpa_v_p   = 1'b0;
        cpa_p     = {5'd0, hi_reg};
        cpb_v_p   = 1'b0;
        cpb_p     = la_new;
        reproc_p  = 1'b0;
        do_fail   = 1'b0;
        do_drop   = 1'b0;
        if (cmd.flush)
        begin
            case (phase_reg)
                PH_ZERO:
                begin
                    lit_n_p = 2'd1;
                    lit0_p  = CH_NUL;
                    ph_n    = PH_IDLE;
                end
                PH_X, PH_U, PH_U4, PH_UBRACE: do_fail = 1'b1;
                PH_LA_BS, PH_LA_U:
                begin
                    cpa_v_p = 1'b1;
                    hi_n    = 16'd0;
                    ph_n    = PH_IDLE;
                end
                PH_LA_D: do_drop = 1'b1;
                default: ph_n = PH_IDLE;
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (byte_reg == CH_BSLASH) ph_n = PH_BSLASH;
                    else lit_n_p = 2'd1;
                end
                PH_BSLASH:
                begin
                    ph_n    = PH_IDLE;
                    lit_n_p = 2'd1;
                    case (byte_reg)
                        CH_LO_N: lit0_p = CH_LF;
                        CH_LO_T: lit0_p = CH_TAB;
                        CH_LO_R: lit0_p = CH_CR;
                        CH_LO_B: lit0_p = CH_BS;
                        CH_LO_F: lit0_p = CH_FF;
                        CH_LO_V: lit0_p = CH_VT;
                        CH_ZERO:
                        begin
                            lit_n_p = 2'd0;
                            ph_n    = PH_ZERO;
                        end
                        CH_LO_X:
                        begin
                            lit_n_p = 2'd0;
                            ph_n    = PH_X;
                            held_n  = '0;
                            acc_n   = 21'd0;
                        end
                        CH_LO_U:
                        begin
                            lit_n_p = 2'd0;
                            ph_n    = PH_U;
                            held_n  = '0;
                            acc_n   = 21'd0;
                        end
                        CH_CR:
                        begin
                            lit_n_p = 2'd0;
                            ph_n    = PH_CR;
                        end
                        CH_LF:   lit_n_p = 2'd0;
                        default: lit0_p = byte_reg;
                    endcase
                end
                PH_CR:
                begin
                    ph_n     = PH_IDLE;
                    reproc_p = (byte_reg != CH_LF);
                end
                PH_ZERO:
                begin
                    ph_n     = PH_IDLE;
                    lit_n_p  = 2'd1;
                    lit0_p   = (byte_reg >= CH_ZERO && byte_reg <= CH_NINE) ? CH_ZERO : CH_NUL;
                    reproc_p = 1'b1;
                end
                PH_X:
                begin
                    if (!hx)
                    begin
                        do_fail  = 1'b1;
                        reproc_p = 1'b1;
                    end
                    else if (held_reg == '0)
                    begin
                        hold_we = 1'b1;
                        held_n  = CNT_W'(1);
                        acc_n   = {17'd0, hv};
                    end
                    else
                    begin
                        cpa_v_p = 1'b1;
                        cpa_p   = {13'd0, acc_reg[3:0], hv};
                        ph_n    = PH_IDLE;
                        held_n  = '0;
                    end
                end
                PH_U:
                begin
                    if (byte_reg == CH_LBRACE)
                    begin
                        ph_n   = PH_UBRACE;
                        held_n = '0;
                        acc_n  = 21'd0;
                    end
                    else if (!hx)
                    begin
                        do_fail  = 1'b1;
                        reproc_p = 1'b1;
                    end
                    else
                    begin
                        ph_n      = PH_U4;
                        hold_we   = 1'b1;
                        hold_addr = '0;
                        held_n    = CNT_W'(1);
                        acc_n     = {17'd0, hv};
                    end
                end
                PH_U4:
                begin
                    if (!hx)
                    begin
                        do_fail  = 1'b1;
                        reproc_p = 1'b1;
                    end
                    else
                    begin
                        acc_n = {5'd0, u4_new};
                        if (held_reg < CNT_W'(3))
                        begin
                            hold_we = 1'b1;
                            held_n  = held_reg + CNT_W'(1);
                        end
                        else
                        begin
                            held_n = '0;
                            if (u4_new >= SURR_HI_MIN && u4_new <= SURR_HI_MAX)
                            begin
                                hi_n = u4_new;
                                ph_n = PH_LA_BS;
                            end
                            else
                            begin
                                cpa_v_p = 1'b1;
                                cpa_p   = {5'd0, u4_new};
                                ph_n    = PH_IDLE;
                            end
                        end
                    end
                end
                PH_UBRACE:
                begin
                    if (hx && brace_nc <= CP_MAX)
                    begin
                        acc_n = brace_nc[20:0];
                        if (held_reg < CNT_W'(HOLD_DEPTH))
                        begin
                            hold_we = 1'b1;
                            held_n  = held_reg + CNT_W'(1);
                        end
                    end
                    else if (!hx && byte_reg == CH_RBRACE && held_reg != '0)
                    begin
                        cpa_v_p = 1'b1;
                        cpa_p   = acc_reg;
                        ph_n    = PH_IDLE;
                        held_n  = '0;
                    end
                    else
                    begin
                        do_fail  = 1'b1;
                        reproc_p = 1'b1;
                    end
                end
                PH_LA_BS:
                begin
                    if (byte_reg == CH_BSLASH) ph_n = PH_LA_U;
                    else
                    begin
                        cpa_v_p  = 1'b1;
                        hi_n     = 16'd0;
                        ph_n     = PH_IDLE;
                        reproc_p = 1'b1;
                    end
                end
                PH_LA_U:
                begin
                    if (byte_reg == CH_LO_U)
                    begin
                        ph_n   = PH_LA_D;
                        held_n = '0;
                        la_n   = 16'd0;
                    end
                    else
                    begin
                        cpa_v_p  = 1'b1;
                        hi_n     = 16'd0;
                        ph_n     = PH_BSLASH;
                        reproc_p = 1'b1;
                    end
                end
                PH_LA_D:
                begin
                    if (!hx)
                    begin
                        do_drop  = 1'b1;
                        reproc_p = 1'b1;
                    end
                    else
                    begin
                        la_n = la_new;
                        if (held_reg < CNT_W'(3))
                        begin
                            hold_we = 1'b1;
                            held_n  = held_reg + CNT_W'(1);
                        end
                        else if (la_new >= SURR_LO_MIN && la_new <= SURR_LO_MAX)
                        begin
                            cpa_v_p = 1'b1;
                            cpa_p   = CP_SUPP + {1'b0, hi_reg[9:0], la_new[9:0]};
                            hi_n    = 16'd0;
                            ph_n    = PH_IDLE;
                            held_n  = '0;
                        end
                        else
                        begin
                            // Unpaired high surrogate, then the new escape stands alone
                            cpa_v_p = 1'b1;
                            held_n  = '0;
                            if (la_new >= SURR_HI_MIN && la_new <= SURR_HI_MAX)
                            begin
                                hi_n = la_new;
                                ph_n = PH_LA_BS;
                            end
                            else
                            begin
                                hi_n    = 16'd0;
                                cpb_v_p = 1'b1;
                                ph_n    = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    ph_n     = PH_IDLE;
                    reproc_p = 1'b1;
                end
            endcase
        end

        // Failed escape: emit its literal form and replay held digits
        if (do_fail)
        begin
            ph_n   = PH_IDLE;
            held_n = '0;
            case (phase_reg)
                PH_X:
                begin
                    lit_n_p = 2'd1;
                    lit0_p  = CH_LO_X;
                    rep_p   = 1'b1;
                end
                PH_U:
                begin
                    lit_n_p = 2'd1;
                    lit0_p  = CH_LO_U;
                end
                PH_U4:
                begin
                    lit_n_p = 2'd1;
                    lit0_p  = CH_LO_U;
                    rep_p   = 1'b1;
                end
                default:
                begin
                    lit_n_p = 2'd2;
                    lit0_p  = CH_LO_U;
                    lit1_p  = CH_LBRACE;
                    rep_p   = 1'b1;
                end
            endcase
        end

        // Lookahead abandoned: emit the high surrogate, resume the escape
        if (do_drop)
        begin
            cpa_v_p = 1'b1;
            hi_n    = 16'd0;
            held_n  = held_reg;
            if (held_reg == '0) ph_n = PH_U;
            else
            begin
                ph_n  = PH_U4;
                acc_n = {5'd0, la_reg};
            end
        end
    end

    // Held digit store
    assign rep_idx_inc = CNT_W'(rep_idx_reg) + CNT_W'(1);
    assign rep_last    = (rep_idx_inc == rep_cnt_reg);
    assign ram_rd_en   = cmd.rd_start | (cmd.rep & ~rep_last);
    assign ram_rd_addr = cmd.rd_start ? '0 : rep_idx_inc[ADDR_W-1:0];

    esud_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_held (
        .clk     (clk),
        .wr_en   (cmd.eval & hold_we),
        .wr_addr (hold_addr[ADDR_W-1:0]),
        .wr_data (byte_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Emit path
    assign out_free = ~out_valid_reg | out_ready;
    assign can_put  = ~pend_valid_reg | out_free;
    assign put_en   = cmd.lit | cmd.rep | cmd.cpa | cmd.cpb;
    always_comb
    begin
        put_byte = lit0_reg;
        if (cmd.rep) put_byte = ram_rd_data;
        else if (cmd.cpa) put_byte = utf8_byte(cpa_reg, cp_idx_reg);
        else if (cmd.cpb) put_byte = utf8_byte({5'd0, cpb_reg}, cp_idx_reg);
    end

    // Move the held byte to the output register on a new put or at the end of the item
    assign out_load = pend_valid_reg && ((put_en && step_cnt_reg < MAX_OUT) || cmd.done);

    // A line continuation always ends in a backslash phase seeing CR or LF
    assign line_inc = (in_byte == CH_CR || in_byte == CH_LF)
                   && (phase_reg == PH_BSLASH || phase_reg == PH_LA_U)
                   && (line_reg != 16'hFFFF);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            acc_reg        <= 21'd0;
            hi_reg         <= 16'd0;
            la_reg         <= 16'd0;
            held_reg       <= '0;
            line_reg       <= 16'd0;
            last_reg       <= 1'b0;
            lit_n_reg      <= 2'd0;
            rep_cnt_reg    <= '0;
            rep_idx_reg    <= '0;
            cpa_v_reg      <= 1'b0;
            cpb_v_reg      <= 1'b0;
            cp_idx_reg     <= 2'd0;
            reproc_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_cnt_reg   <= 5'd0;
        end
        else
        begin
            out_valid_reg <= out_load | (out_valid_reg & ~out_ready);
            if (cmd.accept)
            begin
                last_reg     <= in_last;
                step_cnt_reg <= 5'd0;
                if (line_inc)
                begin
                    line_reg <= line_reg + 16'd1;
                end
            end
            if (cmd.eval)
            begin
                phase_reg   <= ph_n;
                acc_reg     <= acc_n;
                hi_reg      <= hi_n;
                la_reg      <= la_n;
                held_reg    <= held_n;
                lit_n_reg   <= lit_n_p;
                rep_cnt_reg <= rep_p ? held_reg : '0;
                cpa_v_reg   <= cpa_v_p;
                cpb_v_reg   <= cpb_v_p;
                reproc_reg  <= reproc_p;
                cp_idx_reg  <= 2'd0;
            end
            if (cmd.lit)
            begin
                lit_n_reg <= lit_n_reg - 2'd1;
            end
            if (cmd.rd_start)
            begin
                rep_idx_reg <= '0;
            end
            if (cmd.rep)
            begin
                if (rep_last) rep_cnt_reg <= '0;
                else rep_idx_reg <= rep_idx_inc[ADDR_W-1:0];
            end
            if (cmd.cpa)
            begin
                if (status.job_cpa_last)
                begin
                    cpa_v_reg  <= 1'b0;
                    cp_idx_reg <= 2'd0;
                end
                else cp_idx_reg <= cp_idx_reg + 2'd1;
            end
            if (cmd.cpb)
            begin
                if (status.job_cpb_last)
                begin
                    cpb_v_reg  <= 1'b0;
                    cp_idx_reg <= 2'd0;
                end
                else cp_idx_reg <= cp_idx_reg + 2'd1;
            end
            // Keep one byte back so the last of the item can be marked
            if (put_en && step_cnt_reg < MAX_OUT)
            begin
                step_cnt_reg   <= step_cnt_reg + 5'd1;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.done)
            begin
                pend_valid_reg <= 1'b0;
                if (last_reg)
                begin
                    held_reg <= '0;
                    acc_reg  <= 21'd0;
                    la_reg   <= 16'd0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.eval)
        begin
            lit0_reg <= lit0_p;
            lit1_reg <= lit1_p;
            cpa_reg  <= cpa_p;
            cpb_reg  <= cpb_p;
        end
        if (cmd.lit)
        begin
            lit0_reg <= lit1_reg;
        end
        if (put_en && step_cnt_reg < MAX_OUT)
        begin
            pend_byte_reg <= put_byte;
            if (pend_valid_reg)
            begin
                out_byte_reg  <= pend_byte_reg;
                out_last_reg  <= 1'b0;
                out_lines_reg <= line_reg;
            end
        end
        if (cmd.done && pend_valid_reg)
        begin
            out_byte_reg  <= pend_byte_reg;
            out_last_reg  <= 1'b1;
            out_lines_reg <= line_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.plan_lit     = (lit_n_p != 2'd0);
        status.plan_rep     = rep_p && (held_reg != '0);
        status.plan_cpa     = cpa_v_p;
        status.plan_cpb     = cpb_v_p;
        status.plan_reproc  = reproc_p;
        status.plan_idle    = (ph_n == PH_IDLE);
        status.job_lit_one  = (lit_n_reg == 2'd1);
        status.job_rep      = (rep_cnt_reg != '0);
        status.job_rep_last = rep_last;
        status.job_cpa      = cpa_v_reg;
        status.job_cpa_last = (cp_idx_reg == utf8_len(cpa_reg));
        status.job_cpb      = cpb_v_reg;
        status.job_cpb_last = (cp_idx_reg == utf8_len({5'd0, cpb_reg}));
        status.reproc       = reproc_reg;
        status.phase_idle   = (phase_reg == PH_IDLE);
        status.last         = last_reg;
        status.can_put      = can_put;
        status.pend_valid   = pend_valid_reg;
        status.line_cnt     = line_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_lines = out_lines_reg;

endmodule

@@ hw/rtl/esud_ctrl.sv @@
// Controller: sequences evaluation, literal, replay and code point emission per item.
`timescale 1ns / 1ps

module esud_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  esud_pkg::status_t status,
    output esud_pkg::cmd_t    cmd
);

    import esud_pkg::*;

    typedef enum logic [7:0] {
        ST_WAIT   = 8'b0000_0001,
        ST_EVAL   = 8'b0000_0010,
        ST_LIT    = 8'b0000_0100,
        ST_RD     = 8'b0000_1000,
        ST_REPLAY = 8'b0001_0000,
        ST_CPA    = 8'b0010_0000,
        ST_CPB    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;
    logic   do_pick;
    logic   p_lit, p_rep, p_cpa, p_cpb, p_reproc, p_idle;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        do_pick    = 1'b0;
        p_lit      = 1'b0;
        p_rep      = 1'b0;
        p_cpa      = 1'b0;
        p_cpb      = 1'b0;
        p_reproc   = status.reproc;
        p_idle     = status.phase_idle;
        case (state_reg)
            ST_WAIT:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                    flush_next = 1'b0;
                end
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                cmd.flush = flush_reg;
                do_pick   = 1'b1;
                p_lit     = status.plan_lit;
                p_rep     = status.plan_rep;
                p_cpa     = status.plan_cpa;
                p_cpb     = status.plan_cpb;
                p_reproc  = status.plan_reproc;
                p_idle    = status.plan_idle;
            end
            ST_LIT:
            begin
                if (status.can_put)
                begin
                    cmd.lit = 1'b1;
                    if (status.job_lit_one)
                    begin
                        do_pick = 1'b1;
                        p_rep   = status.job_rep;
                        p_cpa   = status.job_cpa;
                        p_cpb   = status.job_cpb;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_start = 1'b1;
                state_next   = ST_REPLAY;
            end
            ST_REPLAY:
            begin
                if (status.can_put)
                begin
                    cmd.rep = 1'b1;
                    if (status.job_rep_last)
                    begin
                        do_pick = 1'b1;
                        p_cpa   = status.job_cpa;
                        p_cpb   = status.job_cpb;
                    end
                end
            end
            ST_CPA:
            begin
                if (status.can_put)
                begin
                    cmd.cpa = 1'b1;
                    if (status.job_cpa_last)
                    begin
                        do_pick = 1'b1;
                        p_cpb   = status.job_cpb;
                    end
                end
            end
            ST_CPB:
            begin
                if (status.can_put)
                begin
                    cmd.cpb = 1'b1;
                    do_pick = status.job_cpb_last;
                end
            end
            ST_DONE:
            begin
                if (status.can_put)
                begin
                    cmd.done   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default: state_next = ST_WAIT;
        endcase

        // Pick the next job, then reprocess, flush or finish
        if (do_pick)
        begin
            if (p_lit) state_next = ST_LIT;
            else if (p_rep) state_next = ST_RD;
            else if (p_cpa) state_next = ST_CPA;
            else if (p_cpb) state_next = ST_CPB;
            else if (p_reproc)
            begin
                state_next = ST_EVAL;
                flush_next = 1'b0;
            end
            else if (status.last && !p_idle)
            begin
                state_next = ST_EVAL;
                flush_next = 1'b1;
            end
            else state_next = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign in_ready = (state_reg == ST_WAIT);

endmodule

@@ hw/rtl/escape_sequence_to_utf8_decoder.sv @@
// Top level of the string escape sequence to UTF-8 decoder.
`timescale 1ns / 1ps
`include "escape_sequence_to_utf8_decoder_assert.svh"

// Usage:
//   s_axis carries source bytes of a string body; tlast marks the final byte,
//   after which any open escape is resolved or flushed.
//   m_axis carries decoded UTF-8 bytes, tlast on the last byte caused by an
//   input item, with the running line-continuation count alongside.
//   An item that causes no output (backslash, escape digits) yields nothing.
// Timing:
//   The controller handles one input item at a time. A plain byte passes
//   through the wait, evaluate, literal and done states before the next
//   acceptance. Each escape re-evaluation adds an evaluate state, each
//   emitted byte a put step, and a replay of held digits an extra read
//   state for the registered read of the held-digit RAM.
// Reset:
//   rst_n clears the parser to idle, the line count to zero and the output
//   stage to empty. The held-digit RAM is not cleared; entries are always
//   written before they are read.
// Backpressure:
//   A one-byte holding stage and the output register hold results while
//   m_axis_tready is low; emission, and then input acceptance, pause.
module escape_sequence_to_utf8_decoder #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] lines_so_far
    output logic        m_axis_tlast
);

    import esud_pkg::*;

    cmd_t        dp_cmd;
    status_t     dp_status;
    logic [7:0]  out_byte;
    logic [15:0] out_lines;

    esud_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    esud_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (out_byte),
        .out_last  (m_axis_tlast),
        .out_lines (out_lines)
    );

    assign m_axis_tdata = {out_lines, out_byte};

    // Checks
    `ESUD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")
    `ESUD_ASSERT_NOW(a_pend_empty_on_accept, s_axis_tvalid && s_axis_tready, !dp_status.pend_valid, "held byte left over from previous item")
    `ESUD_ASSERT_NEXT(a_lines_monotonic, 1'b1, dp_status.line_cnt >= $past(dp_status.line_cnt), "line count went backwards")

endmodule

@@ tb/escape_decoder_checker.sv @@
// Checker: watches both streams, predicts decoded bytes and compares them.
`timescale 1ns / 1ps

module escape_decoder_checker #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] lines_so_far
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_count
);
    import esud_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] lines;
    } dec_byte_t;

    localparam int OUT_CAP = 20;

    dec_byte_t  decoded_q[$];
    dec_byte_t  step_buf[$];

    phase_t      ph;
    logic [20:0] acc;
    logic [15:0] hi_surr;
    logic [15:0] la_acc;
    logic [7:0]  held[HOLD_DEPTH];
    int          held_n;
    logic [15:0] lines;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic emit(input logic [7:0] b);
        dec_byte_t e;
        if (step_buf.size() < OUT_CAP)
        begin
            e.out_byte = b;
            e.out_last = 1'b0;
            e.lines = 16'd0;
            step_buf.insert(step_buf.size(), e);
        end
    endtask

    task automatic emit_cp(input logic [20:0] cp);
        if (cp < 21'h80)
            emit(cp[7:0]);
        else if (cp < 21'h800)
        begin
            emit({3'b110, cp[10:6]});
            emit({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            emit({4'b1110, cp[15:12]});
            emit({2'b10, cp[11:6]});
            emit({2'b10, cp[5:0]});
        end
        else
        begin
            emit({5'b11110, cp[20:18]});
            emit({2'b10, cp[17:12]});
            emit({2'b10, cp[11:6]});
            emit({2'b10, cp[5:0]});
        end
    endtask

    function automatic bit hexd(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] nib(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= "0" && b <= "9") v = b - "0";
        else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
        else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
        return v[3:0];
    endfunction

    task automatic keep(input logic [7:0] b);
        if (held_n < HOLD_DEPTH)
        begin
            held[held_n] = b;
            held_n++;
        end
    endtask

    task automatic replay();
        for (int i = 0; i < held_n; i++) emit(held[i]);
    endtask

    task automatic abandon();
        case (ph)
            PH_X:      begin emit("x"); replay(); end
            PH_U:      emit("u");
            PH_U4:     begin emit("u"); replay(); end
            PH_UBRACE: begin emit("u"); emit("{"); replay(); end
            default:   ;
        endcase
        ph = PH_IDLE;
        held_n = 0;
    endtask

    task automatic close_u4(input logic [15:0] cp);
        held_n = 0;
        if (cp >= SURR_HI_MIN && cp <= SURR_HI_MAX)
        begin
            hi_surr = cp;
            ph = PH_LA_BS;
        end
        else
        begin
            emit_cp({5'd0, cp});
            ph = PH_IDLE;
        end
    endtask

    task automatic unpair();
        emit_cp({5'd0, hi_surr});
        hi_surr = 16'd0;
        if (held_n == 0)
            ph = PH_U;
        else
        begin
            ph = PH_U4;
            acc = {5'd0, la_acc};
        end
    endtask

    task automatic bump_lines();
        if (lines != 16'hFFFF) lines++;
    endtask

    // Process one byte in the current phase; set again when it must be re-taken.
    task automatic consume(input logic [7:0] b, output bit again);
        logic [24:0] nc;
        again = 1'b0;
        case (ph)
            PH_IDLE:
                if (b == CH_BSLASH) ph = PH_BSLASH;
                else emit(b);
            PH_BSLASH:
            begin
                ph = PH_IDLE;
                case (b)
                    CH_LO_N: emit(CH_LF);
                    CH_LO_T: emit(CH_TAB);
                    CH_LO_R: emit(CH_CR);
                    CH_LO_B: emit(CH_BS);
                    CH_LO_F: emit(CH_FF);
                    CH_LO_V: emit(CH_VT);
                    CH_ZERO: ph = PH_ZERO;
                    CH_LO_X: begin ph = PH_X; held_n = 0; acc = 21'd0; end
                    CH_LO_U: begin ph = PH_U; held_n = 0; acc = 21'd0; end
                    CH_CR:   begin bump_lines(); ph = PH_CR; end
                    CH_LF:   bump_lines();
                    default: emit(b);
                endcase
            end
            PH_CR:
            begin
                ph = PH_IDLE;
                again = (b != CH_LF);
            end
            PH_ZERO:
            begin
                ph = PH_IDLE;
                emit((b >= CH_ZERO && b <= CH_NINE) ? CH_ZERO : CH_NUL);
                again = 1'b1;
            end
            PH_X:
                if (!hexd(b)) begin abandon(); again = 1'b1; end
                else if (held_n == 0)
                begin
                    keep(b);
                    acc = {17'd0, nib(b)};
                end
                else
                begin
                    emit_cp({13'd0, acc[3:0], nib(b)});
                    ph = PH_IDLE;
                    held_n = 0;
                end
            PH_U:
                if (b == CH_LBRACE)
                begin
                    ph = PH_UBRACE;
                    held_n = 0;
                    acc = 21'd0;
                end
                else if (!hexd(b)) begin abandon(); again = 1'b1; end
                else
                begin
                    ph = PH_U4;
                    held_n = 0;
                    keep(b);
                    acc = {17'd0, nib(b)};
                end
            PH_U4:
                if (!hexd(b)) begin abandon(); again = 1'b1; end
                else
                begin
                    acc = {5'd0, acc[11:0], nib(b)};
                    if (held_n < 3) keep(b);
                    else close_u4(acc[15:0]);
                end
            PH_UBRACE:
                if (hexd(b))
                begin
                    nc = {acc, nib(b)};
                    if (nc > CP_MAX) begin abandon(); again = 1'b1; end
                    else
                    begin
                        acc = nc[20:0];
                        keep(b);
                    end
                end
                else if (b == CH_RBRACE && held_n > 0)
                begin
                    emit_cp(acc);
                    ph = PH_IDLE;
                    held_n = 0;
                end
                else begin abandon(); again = 1'b1; end
            PH_LA_BS:
                if (b == CH_BSLASH) ph = PH_LA_U;
                else
                begin
                    emit_cp({5'd0, hi_surr});
                    hi_surr = 16'd0;
                    ph = PH_IDLE;
                    again = 1'b1;
                end
            PH_LA_U:
                if (b == CH_LO_U)
                begin
                    ph = PH_LA_D;
                    held_n = 0;
                    la_acc = 16'd0;
                end
                else
                begin
                    emit_cp({5'd0, hi_surr});
                    hi_surr = 16'd0;
                    ph = PH_BSLASH;
                    again = 1'b1;
                end
            PH_LA_D:
                if (!hexd(b)) begin unpair(); again = 1'b1; end
                else
                begin
                    la_acc = {la_acc[11:0], nib(b)};
                    if (held_n < 3) keep(b);
                    else if (la_acc >= SURR_LO_MIN && la_acc <= SURR_LO_MAX)
                    begin
                        emit_cp(CP_SUPP + {1'b0, hi_surr[9:0], la_acc[9:0]});
                        hi_surr = 16'd0;
                        ph = PH_IDLE;
                        held_n = 0;
                    end
                    else
                    begin
                        emit_cp({5'd0, hi_surr});
                        hi_surr = 16'd0;
                        close_u4(la_acc);
                    end
                end
            default:
            begin
                ph = PH_IDLE;
                again = 1'b1;
            end
        endcase
    endtask

    // Resolve any open escape at the end of the input.
    task automatic flush_open();
        while (ph != PH_IDLE)
        begin
            case (ph)
                PH_ZERO: begin emit(CH_NUL); ph = PH_IDLE; end
                PH_X, PH_U, PH_U4, PH_UBRACE: abandon();
                PH_LA_BS, PH_LA_U:
                begin
                    emit_cp({5'd0, hi_surr});
                    hi_surr = 16'd0;
                    ph = PH_IDLE;
                end
                PH_LA_D: unpair();
                default: ph = PH_IDLE;
            endcase
        end
        held_n = 0;
        acc = 21'd0;
        la_acc = 16'd0;
    endtask

    task automatic predict_item(input logic [7:0] b, input logic last);
        bit again;
        dec_byte_t e;
        step_buf.delete();
        do consume(b, again); while (again);
        if (last) flush_open();
        for (int k = 0; k < step_buf.size(); k++)
        begin
            e = step_buf[k];
            e.out_last = (k == step_buf.size() - 1);
            e.lines = lines;
            decoded_q.insert(decoded_q.size(), e);
        end
    endtask

    // Watch both channels and compare each result item with the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin
        dec_byte_t e;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            acc = 21'd0;
            hi_surr = 16'd0;
            la_acc = 16'd0;
            held_n = 0;
            lines = 16'd0;
            fail_count = 0;
            decoded_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                    report($sformatf("unexpected item %h", m_axis_tdata));
                else
                begin
                    e = decoded_q.pop_front();
                    if (m_axis_tdata[7:0] !== e.out_byte)
                        report($sformatf("out_byte %h, want %h", m_axis_tdata[7:0], e.out_byte));
                    if (m_axis_tlast !== e.out_last)
                        report($sformatf("out_last %b, want %b", m_axis_tlast, e.out_last));
                    if (m_axis_tdata[23:8] !== e.lines)
                        report($sformatf("lines %0d, want %0d", m_axis_tdata[23:8], e.lines));
                end
            end
            pending_count = decoded_q.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Testbench top: drives source bytes, applies backpressure and gives the verdict.
`timescale 1ns / 1ps

module testbench;
    import esud_pkg::*;

    localparam int  RANDOM_ITEMS = 220;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_count;
    longint      cycle_count;
    bit          calm;
    bit          hold_off;
    int          sent;

    logic [7:0]  src_bytes[$];
    logic        src_lasts[$];

    escape_sequence_to_utf8_decoder u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    escape_decoder_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else m_axis_tready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // Hold the receiver off once for a long stretch while the sender keeps offering.
    initial
    begin
        hold_off = 1'b0;
        wait (sent >= 240);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic add(input logic [7:0] b, input logic last = 1'b0);
        src_bytes.insert(src_bytes.size(), b);
        src_lasts.insert(src_lasts.size(), last);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        string digits;
        digits = ($urandom_range(1)) ? "0123456789abcdef" : "0123456789ABCDEF";
        return digits[v];
    endfunction

    task automatic add_hex(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) add(hex_char(int'(v[i*4 +: 4])));
    endtask

    // One well-formed or deliberately broken escape with random content.
    task automatic add_random_escape();
        int pick;
        string letters;
        letters = "ntrbfv0'\"q";
        pick = $urandom_range(13);
        add(CH_BSLASH);
        case (pick)
            0: add(letters[$urandom_range(9)]);
            1: begin add(CH_LO_X); add_hex($urandom, 2); end
            2: begin add(CH_LO_U); add_hex($urandom_range(16'hD7FF), 4); end
            3:
            begin
                add(CH_LO_U); add_hex($urandom_range(16'hDBFF, 16'hD800), 4);
                add_str("\\u"); add_hex($urandom_range(16'hDFFF, 16'hDC00), 4);
            end
            4: begin add(CH_LO_U); add_hex($urandom_range(16'hDBFF, 16'hD800), 4); end
            5:
            begin
                add_str("u{"); add_hex($urandom_range(21'h10FFFF), $urandom_range(6, 1));
                add(CH_RBRACE);
            end
            6: add(($urandom_range(1)) ? CH_LF : CH_CR);
            7: begin add(CH_CR); add(CH_LF); end
            8: begin add(CH_LO_X); add_hex($urandom, $urandom_range(1)); add("g"); end
            9: begin add(CH_LO_U); add_hex($urandom, $urandom_range(3)); add("z"); end
            10: begin add_str("u{"); add_hex($urandom, $urandom_range(18)); end
            11: begin add(CH_ZERO); add($urandom_range(1) ? "7" : "a"); end
            12:
            begin
                add(CH_LO_U); add_hex($urandom_range(16'hDBFF, 16'hD800), 4);
                add_str("\\u"); add_hex($urandom_range(16'hFFFF), $urandom_range(4));
            end
            default: add(8'($urandom_range(255)));
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tlast = 1'b0;
        calm = 1'b0;
        sent = 0;

        // Directed: extremes, every escape letter and the special cases.
        add(8'h00); add(8'hFF);
        add_str("\\n\\t\\r\\b\\f\\v\\q\\0");
        add_str("\\07\\x4g\\u{}\\u{110000}\\u{10FFFF}");
        add_str("\\uD83D\\uDE00\\uD800x\\uDC00\\uD800\\n");
        add_str("\\u{000000000000000000041}\\u{12");
        add_str("\\"); add(CH_LF); add_str("\\"); add(CH_CR); add(CH_LF);
        add_str("\\uD801\\u12"); add(8'h41, 1'b1);
        add(CH_BSLASH, 1'b1);
        add_str("\\"); add(CH_ZERO, 1'b1);

        // Random: mostly escapes with random content, some noise.
        while (src_bytes.size() < 120 + RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 60) add_random_escape();
            else add(8'($urandom_range(255)));
            if ($urandom_range(99) < 4) src_lasts[src_lasts.size() - 1] = 1'b1;
        end
        add(8'h2E, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sender: offer items with random gaps.
        while (sent < src_bytes.size())
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready) sent++;
            calm = (sent >= 150 && sent < 230);
            if (sent < src_bytes.size() && (calm || $urandom_range(99) >= 15 || (s_axis_tvalid
                    && !s_axis_tready)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= src_bytes[sent];
                s_axis_tlast <= src_lasts[sent];
            end
            else
                s_axis_tvalid <= 1'b0;
        end

        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
